>>> hdl/pqll_pkg.sv
// shared types, codes and constants for the piecewise quadratic loss lookup
package pqll_pkg;

  localparam int unsigned DEF_TABLE_DEPTH    = 64;
  localparam int unsigned DEF_OBSERVED_LIMIT = 30000;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RL_W       = 16;
  localparam int unsigned EC_W       = 7;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned MUL_STEPS  = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_READ_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b1;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ABOVE = 2'd1;
  localparam logic [1:0] ST_BELOW = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [5:0]         entry_index;
    logic [31:0]        entry_key;
    logic signed [31:0] over_quad_coef;
    logic signed [31:0] over_lin_coef;
    logic signed [31:0] under_quad_coef;
    logic signed [31:0] under_lin_coef;
    logic [31:0]        observed;
    logic [31:0]        predicted;
    logic [31:0]        segment_length;
  } pqll_in_t;

  typedef struct packed {
    logic signed [63:0] loss;
    logic [1:0]         status;
  } pqll_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MULF, S_MULF_WB, S_CLAMP, S_SRCH_RD, S_SRCH_CMP,
    S_RD_LO, S_RD_UP, S_AVG, S_MUL, S_COMB, S_FIN
  } pqll_state_e;

  // multiplier operand selection, also used as the product tag
  typedef enum logic [3:0] {
    MS_NONE, MS_PRED, MS_D0D0, MS_D0D1, MS_D1D0, MS_D1D1, MS_D0L, MS_D1L,
    MS_DD0Q, MS_DD1Q, MS_DD2Q, MS_DD3Q
  } pqll_mul_e;

  typedef struct packed {
    logic       in_take;
    logic       latch_in;
    logic       div_step;
    logic       clamp;
    logic       set_diff;
    logic       cap_lo;
    logic       cap_up;
    logic       clr_acc;
    logic       comb;
    logic       out_load;
    logic       out_empty;
    pqll_mul_e  mul_sel;
    logic [1:0] status;
  } pqll_cmd_t;

  typedef struct packed {
    logic is_eval;
    logic do_div;
    logic key_ge;
    logic obs_zero;
  } pqll_stat_t;

endpackage

>>> hdl/pqll_ram.sv
// generic single write, single read ram with registered read data
module pqll_ram #(
  parameter int unsigned W  = 32,
  parameter int unsigned D  = 64,
  parameter int unsigned AW = $clog2(D)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/pqll_ctrl.sv
// sequencer for load, rescale, search and loss evaluation
module pqll_ctrl import pqll_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned IW          = $clog2(TABLE_DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  logic [EC_W-1:0] entry_count_i,
  input  pqll_stat_t      st_i,
  output pqll_cmd_t       cmd_o,
  output logic [IW-1:0]   raddr_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  pqll_state_e   state_q, state_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] up_q, up_d, low_q, low_d;
  logic [1:0]    code_q, code_d;
  logic          ov_q, ov_d;
  logic [CW-1:0] n_cnt;

  assign n_cnt = (32'(entry_count_i) >= 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                          : CW'(entry_count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      up_q    <= '0;
      low_q   <= '0;
      code_q  <= ST_OK;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      up_q    <= up_d;
      low_q   <= low_d;
      code_q  <= code_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    up_d          = up_q;
    low_d         = low_q;
    code_d        = code_q;
    ov_d          = ov_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MS_NONE;
    cmd_o.status  = code_q;
    raddr_o       = idx_q[IW-1:0];
    in_stall_o    = 1'b1;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.in_take = 1'b1;
          if (st_i.is_eval) begin
            cmd_o.latch_in = 1'b1;
            code_d  = ST_OK;
            cnt_d   = '0;
            state_d = st_i.do_div ? S_DIV : S_CLAMP;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          state_d = S_MULF;
        end
      end
      S_MULF: begin
        cmd_o.mul_sel = MS_PRED;
        state_d = S_MULF_WB;
      end
      S_MULF_WB: state_d = S_CLAMP;
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        idx_d = '0;
        if (n_cnt == '0) begin
          code_d  = ST_EMPTY;
          state_d = S_FIN;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: state_d = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (st_i.key_ge) begin
          up_d = idx_q[IW-1:0];
          if (st_i.obs_zero) begin
            low_d = idx_q[IW-1:0];
          end else if (idx_q == '0) begin
            low_d  = '0;
            code_d = ST_BELOW;
          end else begin
            low_d = IW'(idx_q - CW'(1));
          end
          state_d = S_RD_LO;
        end else if (CW'(idx_q + CW'(1)) == n_cnt) begin
          up_d    = IW'(n_cnt - CW'(1));
          low_d   = IW'(n_cnt - CW'(1));
          code_d  = ST_ABOVE;
          state_d = S_RD_LO;
        end else begin
          idx_d   = CW'(idx_q + CW'(1));
          state_d = S_SRCH_RD;
        end
      end
      S_RD_LO: begin
        raddr_o = low_q;
        cmd_o.set_diff = 1'b1;
        state_d = S_RD_UP;
      end
      S_RD_UP: begin
        raddr_o = up_q;
        cmd_o.cap_lo = 1'b1;
        state_d = S_AVG;
      end
      S_AVG: begin
        cmd_o.cap_up  = 1'b1;
        cmd_o.clr_acc = 1'b1;
        cnt_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        case (cnt_q)
          6'd0:    cmd_o.mul_sel = MS_D0D0;
          6'd1:    cmd_o.mul_sel = MS_D0D1;
          6'd2:    cmd_o.mul_sel = MS_D1D0;
          6'd3:    cmd_o.mul_sel = MS_D1D1;
          6'd4:    cmd_o.mul_sel = MS_D0L;
          6'd5:    cmd_o.mul_sel = MS_D1L;
          6'd6:    cmd_o.mul_sel = MS_DD0Q;
          6'd7:    cmd_o.mul_sel = MS_DD1Q;
          6'd8:    cmd_o.mul_sel = MS_DD2Q;
          6'd9:    cmd_o.mul_sel = MS_DD3Q;
          default: cmd_o.mul_sel = MS_NONE;
        endcase
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(MUL_STEPS)) begin
          state_d = S_COMB;
        end
      end
      S_COMB: begin
        cmd_o.comb = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!ov_q || !out_stall_i) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_empty = (code_q == ST_EMPTY);
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

endmodule

>>> hdl/pqll_dp.sv
// datapath: table memories, divider lanes, shared multiplier and output register
module pqll_dp import pqll_pkg::*; #(
  parameter int unsigned TABLE_DEPTH    = DEF_TABLE_DEPTH,
  parameter int unsigned OBSERVED_LIMIT = DEF_OBSERVED_LIMIT,
  parameter int unsigned IW             = $clog2(TABLE_DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pqll_in_t        in_data_i,
  input  logic [RL_W-1:0] read_length_i,
  input  pqll_cmd_t       cmd_i,
  input  logic [IW-1:0]   raddr_i,
  output pqll_stat_t      st_o,
  output pqll_out_t       out_data_o
);

  localparam logic [31:0] OBS_MAX = 32'(OBSERVED_LIMIT * 256);

  logic [31:0]         key_rd;
  logic [127:0]        coef_rd;
  logic                we;
  logic [63:0]         pred_q;
  logic [31:0]         obs_q, seg_q;
  logic [RL_W-1:0]     rs_q, ro_q;
  logic [RL_W:0]       rs_sh, ro_sh;
  logic                ge_s, ge_o;
  logic                over_q;
  logic [63:0]         d_q;
  logic signed [31:0]  loq_q, lol_q;
  logic [63:0]         sel_half;
  logic [32:0]         qsum, lsum;
  logic [31:0]         q_avg, l_avg;
  logic [31:0]         qmag_q, lmag_q;
  logic                qneg_q, lneg_q;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         prod_q;
  pqll_mul_e           tag_q;
  logic [127:0]        dd_q;
  logic [95:0]         tb_q;
  logic [159:0]        ta_q;
  logic signed [161:0] ta_s, tb_s, n_q;
  logic signed [63:0]  loss_sat;
  pqll_out_t           res_q;

  assign we = cmd_i.in_take && (in_data_i.operation == OP_LOAD)
              && (32'(in_data_i.entry_index) < 32'(TABLE_DEPTH));

  pqll_ram #(.W(32), .D(TABLE_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (IW'(in_data_i.entry_index)),
    .wdata_i (in_data_i.entry_key),
    .raddr_i (raddr_i),
    .rdata_o (key_rd)
  );

  // over pair in the upper half, under pair in the lower half
  pqll_ram #(.W(128), .D(TABLE_DEPTH)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (IW'(in_data_i.entry_index)),
    .wdata_i ({in_data_i.over_quad_coef, in_data_i.over_lin_coef,
               in_data_i.under_quad_coef, in_data_i.under_lin_coef}),
    .raddr_i (raddr_i),
    .rdata_o (coef_rd)
  );

  assign st_o.is_eval  = (in_data_i.operation == OP_EVAL);
  assign st_o.do_div   = (in_data_i.segment_length != '0) && (read_length_i != '0);
  assign st_o.key_ge   = (key_rd >= obs_q);
  assign st_o.obs_zero = (obs_q == '0);

  // restoring division, one quotient bit per lane per cycle
  always_comb begin
    rs_sh = {rs_q, seg_q[31]};
    ro_sh = {ro_q, obs_q[31]};
    ge_s  = rs_sh >= {1'b0, read_length_i};
    ge_o  = ro_sh >= {1'b0, read_length_i};
  end

  always_comb begin
    sel_half = over_q ? coef_rd[127:64] : coef_rd[63:0];
    qsum     = 33'($signed({loq_q[31], loq_q}) + $signed({sel_half[63], sel_half[63:32]}));
    lsum     = 33'($signed({lol_q[31], lol_q}) + $signed({sel_half[31], sel_half[31:0]}));
    q_avg    = qsum[32:1];
    l_avg    = lsum[32:1];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MS_PRED: begin mul_a = pred_q[31:0]; mul_b = seg_q;          end
      MS_D0D0: begin mul_a = d_q[31:0];    mul_b = d_q[31:0];      end
      MS_D0D1: begin mul_a = d_q[31:0];    mul_b = d_q[63:32];     end
      MS_D1D0: begin mul_a = d_q[63:32];   mul_b = d_q[31:0];      end
      MS_D1D1: begin mul_a = d_q[63:32];   mul_b = d_q[63:32];     end
      MS_D0L:  begin mul_a = d_q[31:0];    mul_b = lmag_q;         end
      MS_D1L:  begin mul_a = d_q[63:32];   mul_b = lmag_q;         end
      MS_DD0Q: begin mul_a = dd_q[31:0];   mul_b = qmag_q;         end
      MS_DD1Q: begin mul_a = dd_q[63:32];  mul_b = qmag_q;         end
      MS_DD2Q: begin mul_a = dd_q[95:64];  mul_b = qmag_q;         end
      MS_DD3Q: begin mul_a = dd_q[127:96]; mul_b = qmag_q;         end
      default: begin mul_a = '0;           mul_b = '0;             end
    endcase
  end

  always_comb begin
    ta_s = $signed({2'b00, ta_q});
    tb_s = $signed({58'd0, tb_q, 8'd0});
    if (n_q[161:79] == '0 || n_q[161:79] == '1) begin
      loss_sat = n_q[79:16];
    end else if (n_q[161]) begin
      loss_sat = {1'b1, 63'd0};
    end else begin
      loss_sat = {1'b0, {63{1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= MS_NONE;
    end else begin
      tag_q <= cmd_i.mul_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    if (cmd_i.latch_in) begin
      pred_q <= {32'd0, in_data_i.predicted};
      obs_q  <= in_data_i.observed;
      seg_q  <= in_data_i.segment_length;
      rs_q   <= '0;
      ro_q   <= '0;
    end
    if (cmd_i.div_step) begin
      seg_q <= {seg_q[30:0], ge_s};
      obs_q <= {obs_q[30:0], ge_o};
      rs_q  <= ge_s ? RL_W'(rs_sh - {1'b0, read_length_i}) : rs_sh[RL_W-1:0];
      ro_q  <= ge_o ? RL_W'(ro_sh - {1'b0, read_length_i}) : ro_sh[RL_W-1:0];
    end
    if (cmd_i.clamp) begin
      obs_q <= (obs_q > OBS_MAX) ? OBS_MAX : obs_q;
    end
    if (cmd_i.set_diff) begin
      over_q <= pred_q > {32'd0, obs_q};
      d_q    <= (pred_q > {32'd0, obs_q}) ? pred_q - {32'd0, obs_q}
                                          : {32'd0, obs_q} - pred_q;
    end
    if (cmd_i.cap_lo) begin
      loq_q <= sel_half[63:32];
      lol_q <= sel_half[31:0];
    end
    if (cmd_i.cap_up) begin
      qneg_q <= q_avg[31];
      lneg_q <= l_avg[31];
      qmag_q <= q_avg[31] ? 32'(~q_avg + 32'd1) : q_avg;
      lmag_q <= l_avg[31] ? 32'(~l_avg + 32'd1) : l_avg;
    end
    if (cmd_i.clr_acc) begin
      dd_q <= '0;
      tb_q <= '0;
      ta_q <= '0;
    end
    case (tag_q)
      MS_PRED: pred_q <= prod_q;
      MS_D0D0: dd_q <= dd_q + 128'(prod_q);
      MS_D0D1: dd_q <= dd_q + (128'(prod_q) << 32);
      MS_D1D0: dd_q <= dd_q + (128'(prod_q) << 32);
      MS_D1D1: dd_q <= dd_q + (128'(prod_q) << 64);
      MS_D0L:  tb_q <= tb_q + 96'(prod_q);
      MS_D1L:  tb_q <= tb_q + (96'(prod_q) << 32);
      MS_DD0Q: ta_q <= ta_q + 160'(prod_q);
      MS_DD1Q: ta_q <= ta_q + (160'(prod_q) << 32);
      MS_DD2Q: ta_q <= ta_q + (160'(prod_q) << 64);
      MS_DD3Q: ta_q <= ta_q + (160'(prod_q) << 96);
      default: ;
    endcase
    if (cmd_i.comb) begin
      n_q <= (qneg_q ? -ta_s : ta_s) + (lneg_q ? -tb_s : tb_s);
    end
    if (cmd_i.out_load) begin
      res_q.loss   <= cmd_i.out_empty ? 64'sd0 : loss_sat;
      res_q.status <= cmd_i.status;
    end
  end

  assign out_data_o = res_q;

endmodule

>>> hdl/piecewise_quadratic_loss_lookup.sv
// top level of the piecewise quadratic loss lookup
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  in_data_i (pqll_in_t)
//   out      source     out_valid_o/out_stall_i out_data_o (pqll_out_t)
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a load transfer writes one table slot
// an evaluate transfer rescales when segment length and read length are both nonzero,
//   using the 32-step divider, then scans the keys one slot at a time and forms the loss
//   on the shared 32x32 multiplier (ten partial products); an empty table skips scan and
//   multiply
// one item is worked at a time; input stall is high from an evaluate accept until the result is
//   parked in the output register, which frees the input while the result waits
// reset clears control state and both registers; the table holds nothing until loaded
module piecewise_quadratic_loss_lookup import pqll_pkg::*; #(
  parameter int unsigned TABLE_DEPTH    = DEF_TABLE_DEPTH,
  parameter int unsigned OBSERVED_LIMIT = DEF_OBSERVED_LIMIT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pqll_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pqll_out_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  logic [RL_W-1:0] read_length_q;
  logic [EC_W-1:0] entry_count_q;
  pqll_cmd_t       cmd;
  pqll_stat_t      st;
  logic [IW-1:0]   raddr;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_length_q <= '0;
      entry_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_READ_LENGTH: read_length_q <= cfg_data_i;
        REG_ENTRY_COUNT: entry_count_q <= cfg_data_i[EC_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: an evaluation walks an optional divide, clamp, scan, fetch, multiply, combine
  pqll_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_count_i (entry_count_q),
    .st_i          (st),
    .cmd_o         (cmd),
    .raddr_o       (raddr)
  );

  // datapath holds the table, working registers and the output register
  pqll_dp #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .OBSERVED_LIMIT (OBSERVED_LIMIT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_data_i     (in_data_i),
    .read_length_i (read_length_q),
    .cmd_i         (cmd),
    .raddr_i       (raddr),
    .st_o          (st),
    .out_data_o    (out_data_o)
  );

endmodule

>>> hdl/pqll_chk.sv
// port-level checker for the piecewise quadratic loss lookup, bound to the top level
module pqll_chk import pqll_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input pqll_in_t              in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input pqll_out_t             out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY) |-> out_data_o.loss == 64'sd0)
    else $error("empty table result carries nonzero loss");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.operation == OP_EVAL) |=> in_stall_o)
    else $error("evaluate transfer did not occupy the block");

endmodule

bind piecewise_quadratic_loss_lookup pqll_chk u_pqll_chk (.*);
